// ===== design/hcq_pkg.sv =====
// Shared types, codes and the event byte builder for the HCI packet rings.
`default_nettype none
package hcq_pkg;

	localparam int FUNC_W = 2;
	localparam int OPC_W  = 16;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 48;
	localparam int STAT_W = 2;
	localparam int CFG_IW = 3;
	localparam int EV_LW  = 5;
	localparam int EV_IW  = 4;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam func_t FN_CMD  = 2'd0;
	localparam func_t FN_POLL = 2'd1;
	localparam func_t FN_SEND = 2'd2;
	localparam func_t FN_RECV = 2'd3;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_LONG  = 2'd3;

	localparam logic [CFG_IW-1:0] CFG_DEV_ADDR = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_VERSION  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_RV_OPC   = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_RA_OPC   = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_EV_IND   = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_CC_CODE  = 3'd5;

	localparam logic [EV_IW-1:0] LEN_RV    = 4'd15;
	localparam logic [EV_IW-1:0] LEN_RA    = 4'd13;
	localparam logic [EV_IW-1:0] LEN_OTHER = 4'd7;

	localparam byte_t PLEN_RV    = 8'd12;
	localparam byte_t PLEN_RA    = 8'd10;
	localparam byte_t PLEN_OTHER = 8'd4;

	// One byte of a Command Complete event at position idx.
	function automatic byte_t ev_byte(
		input logic [EV_IW-1:0]  idx,
		input logic [OPC_W-1:0]  op,
		input logic              rv,
		input logic              ra,
		input byte_t             ver,
		input logic [ADDR_W-1:0] addr,
		input byte_t             ind,
		input byte_t             code
	);
		byte_t b;
		b = '0;
		case (idx)
			4'd0:  b = ind;
			4'd1:  b = code;
			4'd2:  b = rv ? PLEN_RV : (ra ? PLEN_RA : PLEN_OTHER);
			4'd3:  b = 8'd1;
			4'd4:  b = op[7:0];
			4'd5:  b = op[15:8];
			4'd7:  b = rv ? ver : (ra ? addr[47:40] : 8'd0);
			4'd8:  b = (!rv && ra) ? addr[39:32] : 8'd0;
			4'd9:  b = (!rv && ra) ? addr[31:24] : 8'd0;
			4'd10: b = (!rv && ra) ? addr[23:16] : 8'd0;
			4'd11: b = (!rv && ra) ? addr[15:8] : 8'd0;
			4'd12: b = (!rv && ra) ? addr[7:0] : 8'd0;
			default: b = '0;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== design/hcq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hcq_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/hci_command_event_acl_queues_top.sv =====
// Top level of the HCI controller with its event ring and ACL data ring.
//
//  channel | direction | handshake          | payload
//  in      | to block  | in_valid/in_stall  | func opcode data_byte final_byte empty_packet cap
//  out     | from blk  | out_valid/out_stall| status has_byte out_byte end_of_run
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_index cfg_data
//
// A command writes its event one byte at a time (7, 13 or 15 bytes), then sends its result.
// An ACL send is answered in the output register as it is taken. Poll and receive read the
// length in S_LEN, then take each packet byte through S_FETCH and S_EMIT and the registered
// store read port. Reset clears ring pointers and the assembly count and sets the other
// registers to defaults; stores start unknown. A stall on the output holds the sequencer;
// no new item is taken until the last result of the current one is in the output register.
`default_nettype none
module hci_command_event_acl_queues_top #(
	parameter int EVENT_SLOTS = 8,
	parameter int EVENT_BYTES = 16,
	parameter int ACL_SLOTS   = 8,
	parameter int ACL_BYTES   = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire hcq_pkg::func_t               func,
	input  wire logic [hcq_pkg::OPC_W-1:0]    opcode,
	input  wire hcq_pkg::byte_t               data_byte,
	input  wire logic                         final_byte,
	input  wire logic                         empty_packet,
	input  wire hcq_pkg::byte_t               cap,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output hcq_pkg::status_t                  status,
	output logic                              has_byte,
	output hcq_pkg::byte_t                    out_byte,
	output logic                              end_of_run,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [hcq_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [hcq_pkg::ADDR_W-1:0]   cfg_data
);
	import hcq_pkg::*;

	localparam int EV_SW  = $clog2(EVENT_SLOTS);
	localparam int EV_AW  = $clog2(EVENT_SLOTS * EVENT_BYTES);
	localparam int AC_SW  = $clog2(ACL_SLOTS);
	localparam int AC_AW  = $clog2(ACL_SLOTS * ACL_BYTES);
	localparam int AC_FW  = $clog2(ACL_BYTES + 1);

	typedef enum logic [2:0] {S_IDLE, S_CMD, S_LEN, S_FETCH, S_EMIT} state_t;

	state_t state_q;

	logic [ADDR_W-1:0] dev_addr_q;
	byte_t             version_q;
	logic [OPC_W-1:0]  rv_opc_q;
	logic [OPC_W-1:0]  ra_opc_q;
	byte_t             ev_ind_q;
	byte_t             cc_code_q;

	logic [EV_SW-1:0] ev_wr_q, ev_rd_q;
	logic [AC_SW-1:0] acl_wr_q, acl_rd_q;
	logic [AC_FW-1:0] fill_q;
	logic             drop_q;

	func_t            func_q;
	logic [OPC_W-1:0] op_q;
	byte_t            cap_q;
	logic [EV_IW-1:0] cidx_q, clen_q;
	byte_t            idx_q, n_q;
	logic [EV_AW-1:0] ev_base_q;
	logic [AC_AW-1:0] acl_base_q;

	logic    out_v_q, has_q, end_q;
	status_t st_q;
	byte_t   byte_q;

	logic accept, out_free, out_load;
	logic [EV_SW-1:0] ev_wr_nx, ev_rd_nx;
	logic [AC_SW-1:0] acl_wr_nx, acl_rd_nx;
	logic ev_full, acl_full;

	logic             ev_we, evl_we, acl_we, acll_we;
	logic [EV_AW-1:0] ev_waddr, ev_raddr;
	logic [AC_AW-1:0] acl_waddr, acl_raddr;
	byte_t            ev_wdata, ev_rdata, acl_rdata;
	logic [EV_LW-1:0] evl_rdata;
	logic [AC_FW-1:0] acll_wdata, acll_rdata;

	logic             fits, drop_nx, commit, commit_ok;
	logic [AC_FW-1:0] fill_nx;
	status_t          send_st;
	logic             is_poll, ring_empty;
	byte_t            n_rd;
	logic             rv_hit, ra_hit;
	logic             last_byte;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_v_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign accept    = in_valid && !in_stall;

	assign ev_wr_nx  = (ev_wr_q == EV_SW'(EVENT_SLOTS - 1)) ? '0 : ev_wr_q + 1'b1;
	assign ev_rd_nx  = (ev_rd_q == EV_SW'(EVENT_SLOTS - 1)) ? '0 : ev_rd_q + 1'b1;
	assign acl_wr_nx = (acl_wr_q == AC_SW'(ACL_SLOTS - 1)) ? '0 : acl_wr_q + 1'b1;
	assign acl_rd_nx = (acl_rd_q == AC_SW'(ACL_SLOTS - 1)) ? '0 : acl_rd_q + 1'b1;
	assign ev_full   = (ev_wr_nx == ev_rd_q);
	assign acl_full  = (acl_wr_nx == acl_rd_q);

	// ACL assembly: a byte beyond the slot marks the packet for drop.
	always_comb begin
		fits      = (fill_q < AC_FW'(ACL_BYTES));
		fill_nx   = fits ? fill_q + 1'b1 : fill_q;
		drop_nx   = drop_q | !fits;
		commit    = empty_packet || final_byte;
		commit_ok = 1'b0;
		send_st   = ST_OK;
		if (empty_packet) begin
			send_st   = acl_full ? ST_FULL : ST_OK;
			commit_ok = !acl_full;
		end else if (final_byte) begin
			if (drop_nx) begin
				send_st = ST_LONG;
			end else if (acl_full) begin
				send_st = ST_FULL;
			end else begin
				commit_ok = 1'b1;
			end
		end else if (!fits) begin
			send_st = ST_LONG;
		end
	end

	assign acl_we     = accept && func == FN_SEND && !empty_packet && fits;
	assign acl_waddr  = AC_AW'(acl_wr_q) * AC_AW'(ACL_BYTES) + AC_AW'(fill_q);
	assign acll_we    = accept && func == FN_SEND && commit && commit_ok;
	assign acll_wdata = empty_packet ? '0 : fill_nx;
	assign acl_raddr  = acl_base_q + AC_AW'(idx_q);

	assign rv_hit   = (op_q == rv_opc_q);
	assign ra_hit   = (op_q == ra_opc_q);
	assign ev_we    = (state_q == S_CMD);
	assign ev_waddr = EV_AW'(ev_wr_q) * EV_AW'(EVENT_BYTES) + EV_AW'(cidx_q);
	assign ev_wdata = ev_byte(cidx_q, op_q, rv_hit, ra_hit, version_q, dev_addr_q,
		ev_ind_q, cc_code_q);
	assign evl_we   = ev_we && (cidx_q == clen_q - 1'b1);
	assign ev_raddr = ev_base_q + EV_AW'(idx_q);

	assign is_poll    = (func_q == FN_POLL);
	assign ring_empty = is_poll ? (ev_wr_q == ev_rd_q) : (acl_wr_q == acl_rd_q);
	assign n_rd       = is_poll ? 8'(evl_rdata) : 8'(acll_rdata);
	assign last_byte  = (idx_q + 1'b1 == n_q);

	// The output register is loaded on every cycle that produces a result.
	assign out_load = (state_q == S_IDLE && accept &&
			((func == FN_CMD && ev_full) || func == FN_SEND))
		|| evl_we
		|| (state_q == S_LEN && (ring_empty || n_rd > cap_q || n_rd == '0))
		|| (state_q == S_EMIT && out_free);

	hcq_ram #(.W(BYTE_W), .D(EVENT_SLOTS * EVENT_BYTES)) u_ev_store (
		.clk, .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
		.raddr(ev_raddr), .rdata(ev_rdata)
	);
	hcq_ram #(.W(EV_LW), .D(EVENT_SLOTS)) u_ev_len (
		.clk, .we(evl_we), .waddr(ev_wr_q), .wdata(EV_LW'(clen_q)),
		.raddr(ev_rd_q), .rdata(evl_rdata)
	);
	hcq_ram #(.W(BYTE_W), .D(ACL_SLOTS * ACL_BYTES)) u_acl_store (
		.clk, .we(acl_we), .waddr(acl_waddr), .wdata(data_byte),
		.raddr(acl_raddr), .rdata(acl_rdata)
	);
	hcq_ram #(.W(AC_FW), .D(ACL_SLOTS)) u_acl_len (
		.clk, .we(acll_we), .waddr(acl_wr_q), .wdata(acll_wdata),
		.raddr(acl_rd_q), .rdata(acll_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 48'hDEADBEEF0001 - 48'hDEADBEEF0001 + 48'd244837814042625;
			version_q  <= 8'd9;
			rv_opc_q   <= 16'd4097;
			ra_opc_q   <= 16'd4105;
			ev_ind_q   <= 8'd4;
			cc_code_q  <= 8'd14;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEV_ADDR: dev_addr_q <= cfg_data;
				CFG_VERSION:  version_q  <= cfg_data[7:0];
				CFG_RV_OPC:   rv_opc_q   <= cfg_data[15:0];
				CFG_RA_OPC:   ra_opc_q   <= cfg_data[15:0];
				CFG_EV_IND:   ev_ind_q   <= cfg_data[7:0];
				CFG_CC_CODE:  cc_code_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ev_wr_q    <= '0;
			ev_rd_q    <= '0;
			acl_wr_q   <= '0;
			acl_rd_q   <= '0;
			fill_q     <= '0;
			drop_q     <= 1'b0;
			func_q     <= FN_CMD;
			op_q       <= '0;
			cap_q      <= '0;
			cidx_q     <= '0;
			clen_q     <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			ev_base_q  <= '0;
			acl_base_q <= '0;
			out_v_q    <= 1'b0;
			st_q       <= ST_OK;
			has_q      <= 1'b0;
			byte_q     <= '0;
			end_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q <= func;
						cap_q  <= cap;
						case (func)
							FN_CMD: begin
								if (ev_full) begin
									st_q    <= ST_FULL;
									has_q   <= 1'b0;
									byte_q  <= '0;
									end_q   <= 1'b1;
								end else begin
									op_q    <= opcode;
									cidx_q  <= '0;
									clen_q  <= (opcode == rv_opc_q) ? LEN_RV :
										((opcode == ra_opc_q) ? LEN_RA : LEN_OTHER);
									state_q <= S_CMD;
								end
							end
							FN_SEND: begin
								if (commit) begin
									fill_q <= '0;
									drop_q <= 1'b0;
									if (commit_ok) begin
										acl_wr_q <= acl_wr_nx;
									end
								end else begin
									fill_q <= fill_nx;
									drop_q <= drop_nx;
								end
								st_q    <= send_st;
								has_q   <= 1'b0;
								byte_q  <= '0;
								end_q   <= 1'b1;
							end
							default: state_q <= S_LEN;
						endcase
					end
				end
				S_CMD: begin
					cidx_q <= cidx_q + 1'b1;
					if (evl_we) begin
						ev_wr_q <= ev_wr_nx;
						st_q    <= ST_OK;
						has_q   <= 1'b0;
						byte_q  <= '0;
						end_q   <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LEN: begin
					// The length store read issued from the read slot is valid here.
					if (ring_empty || n_rd > cap_q || n_rd == '0) begin
						st_q    <= ring_empty ? ST_EMPTY :
							((n_rd > cap_q) ? ST_LONG : ST_OK);
						has_q   <= 1'b0;
						byte_q  <= '0;
						end_q   <= 1'b1;
						if (!ring_empty && n_rd <= cap_q) begin
							if (is_poll) begin
								ev_rd_q <= ev_rd_nx;
							end else begin
								acl_rd_q <= acl_rd_nx;
							end
						end
						state_q <= S_IDLE;
					end else begin
						n_q        <= n_rd;
						idx_q      <= '0;
						ev_base_q  <= EV_AW'(ev_rd_q) * EV_AW'(EVENT_BYTES);
						acl_base_q <= AC_AW'(acl_rd_q) * AC_AW'(ACL_BYTES);
						if (is_poll) begin
							ev_rd_q <= ev_rd_nx;
						end else begin
							acl_rd_q <= acl_rd_nx;
						end
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						st_q    <= ST_OK;
						has_q   <= 1'b1;
						byte_q  <= is_poll ? ev_rdata : acl_rdata;
						end_q   <= last_byte;
						idx_q   <= idx_q + 1'b1;
						state_q <= last_byte ? S_IDLE : S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_v_q;
	assign status     = st_q;
	assign has_byte   = has_q;
	assign out_byte   = byte_q;
	assign end_of_run = end_q;
endmodule
`default_nettype wire

// ===== design/hcq_checker.sv =====
// Port-level checks on the result channel of the HCI packet rings, with its bind.
`default_nettype none
module hcq_checker (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire hcq_pkg::status_t       status,
	input wire logic                   has_byte,
	input wire hcq_pkg::byte_t         out_byte,
	input wire logic                   end_of_run
);
	import hcq_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(has_byte)
			&& $stable(out_byte) && $stable(end_of_run))
		else $error("stalled result transfer changed");

	a_nobyte_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> end_of_run && out_byte == 8'd0)
		else $error("result without a byte must close the run and carry zero");

	a_byte_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && has_byte |-> status == ST_OK)
		else $error("packet byte with a failing status");
endmodule

bind hci_command_event_acl_queues_top hcq_checker u_hcq_checker (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .has_byte(has_byte), .out_byte(out_byte), .end_of_run(end_of_run)
);
`default_nettype wire
